### hdl/prescaled_timer_table_defines.svh
// Assertion macros shared by the timer table RTL.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef PRESCALED_TIMER_TABLE_DEFINES_SVH
`define PRESCALED_TIMER_TABLE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PTT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timer table assertion failed");

// Next-cycle implication, checked outside reset.
`define PTT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timer table assertion failed");

`endif

### hdl/ptt_pkg.sv
// Shared types, codes and constants of the prescaled timer table.
// No dependencies.
`default_nettype none

package ptt_pkg;

	localparam int PTT_TIMERS  = 16;
	localparam int MAX_RESULTS = 16;
	localparam int RES_W       = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STOP  = 2'd2;
	localparam logic [1:0] OP_QUERY = 2'd3;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_OVERDUE    = 3'd1;
	localparam logic [2:0] ST_STOP_UNK   = 3'd2;
	localparam logic [2:0] ST_START_DUP  = 3'd3;
	localparam logic [2:0] ST_FULL       = 3'd4;
	localparam logic [2:0] ST_NONE_SCHED = 3'd5;
	localparam logic [2:0] ST_NONE_EXP   = 3'd6;

	typedef struct packed {
		logic [7:0]  id;
		logic [31:0] count;
		logic [15:0] frac;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		entry_t upd;
		logic   overdue;
		logic   expired;
		logic   match;
	} step_res_t;

endpackage

`default_nettype wire

### hdl/ptt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ptt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### hdl/ptt_step.sv
// Shared per-entry unit: tick update of one timer, id compare, expiry check.
// Depends on ptt_pkg.
`default_nettype none

module ptt_step
	import ptt_pkg::*;
(
	input  wire entry_t      ent,
	input  wire logic [15:0] ticks_per_unit,
	input  wire logic [7:0]  key_id,
	output step_res_t        res
);

	entry_t upd;

	always_comb begin
		upd = ent;
		if (ent.frac == 16'd0) begin
			if (ent.count != 32'd0) begin
				upd.count = ent.count - 32'd1;
				upd.frac  = ticks_per_unit - 16'd1;
			end
		end else begin
			upd.frac = ent.frac - 16'd1;
		end
		res.upd     = upd;
		res.overdue = (ent.frac == 16'd0) && (ent.count == 32'd0);
		res.expired = (upd.frac == 16'd0) && (upd.count == 32'd0);
		res.match   = (ent.id == key_id);
	end

endmodule

`default_nettype wire

### hdl/prescaled_timer_table.sv
// Prescaled countdown timer table: sequencer, flag vector and output register.
// Depends on ptt_pkg, ptt_ram, ptt_step and prescaled_timer_table_defines.svh.
//
// Usage: one command per input transfer (opcode, timer_id, limit). Tick,
// start and stop walk the occupied slots through one shared update unit, one
// slot per cycle, and return a single result. A query scans the slot range
// one slot per cycle, pausing at each expired timer until its result is
// loaded, and sends one result per expired timer (up to 16), with
// last_of_run on the final one, or a single status result when nothing is
// listed. The table memory has a single read port. in_stall is high while a
// command is being worked on; a finished result waits in the output
// register, and the next command is taken meanwhile. When the receiver
// holds out_stall the sequencer waits before loading the next result and
// the table is not touched. The user must write ticks_per_unit through
// cfg_wr_en/cfg_wr_data only while idle; the block does not enforce this.
// Reset empties the table, sets ticks_per_unit to 1 and drops out_valid; the
// table memory itself needs no clearing.
`default_nettype none

`include "prescaled_timer_table_defines.svh"

module prescaled_timer_table
	import ptt_pkg::*;
#(
	parameter int TIMERS = PTT_TIMERS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [7:0]  timer_id,
	input  wire logic [31:0] limit,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [7:0]       expired_id,
	output logic [4:0]       active_count,
	output logic             timeout_pending,
	output logic             last_of_run
);

	localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam int CNT_W = $clog2(TIMERS + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_WALK  = 3'd1;
	localparam logic [2:0] S_FIN   = 3'd2;
	localparam logic [2:0] S_QSCAN = 3'd3;
	localparam logic [2:0] S_QRD   = 3'd4;

	logic [2:0]        state_q;
	logic [15:0]       tpu_q;
	logic [CNT_W-1:0]  occ_q;
	logic [TIMERS-1:0] flags_q;
	logic [1:0]        op_q;
	logic [7:0]        id_q;
	logic [31:0]       limit_q;
	logic [2:0]        stat_q;
	logic [CNT_W-1:0]  issue_q;
	logic              halt_q;
	logic              found_q;
	logic [IDX_W-1:0]  pos_q;
	logic              vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [IDX_W-1:0]  q_idx_q;
	logic [RES_W-1:0]  n_q;
	logic              out_valid_q;

	logic              in_xfer;
	logic              out_free;
	logic              out_load;
	logic              issue_en;
	logic              proc_s1;
	logic              walk_done;
	logic              higher_any;
	logic              q_last;
	logic [TIMERS-1:0] flags_compact;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	entry_t            ram_wdata;
	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t            rd_ent;
	step_res_t         step;

	assign in_xfer  = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = ((state_q == S_FIN) || (state_q == S_QRD)) && out_free;
	assign rd_ent   = entry_t'(ram_rdata);

	assign issue_en  = (state_q == S_WALK) && !halt_q && (issue_q < occ_q);
	assign proc_s1   = (state_q == S_WALK) && vld_s1 && !halt_q;
	assign walk_done = (state_q == S_WALK) && !issue_en && (!vld_s1 || halt_q);

	ptt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TIMERS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	ptt_step u_step (
		.ent           (rd_ent),
		.ticks_per_unit(tpu_q),
		.key_id        (id_q),
		.res           (step)
	);

	// Read port: walk order during commands, the scan slot during a query.
	always_comb begin
		ram_re    = issue_en || ((state_q == S_QSCAN) && flags_q[q_idx_q]);
		ram_raddr = (state_q == S_WALK) ? issue_q[IDX_W-1:0] : q_idx_q;
	end

	// Write port: tick write-back, stop compaction, or the new entry of a start.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = step.upd;
		if (proc_s1 && (op_q == OP_TICK) && !step.overdue) begin
			ram_we = 1'b1;
		end else if (proc_s1 && (op_q == OP_STOP) && found_q) begin
			ram_we    = 1'b1;
			ram_waddr = idx_s1 - IDX_W'(1);
			ram_wdata = rd_ent;
		end else if (walk_done && (op_q == OP_START) && !found_q
				&& (occ_q != CNT_W'(TIMERS))) begin
			ram_we    = 1'b1;
			ram_waddr = occ_q[IDX_W-1:0];
			ram_wdata = '{id: id_q, count: limit_q, frac: 16'd0};
		end
	end

	always_comb begin
		higher_any = 1'b0;
		for (int k = 0; k < TIMERS; k++) begin
			if (IDX_W'(k) > q_idx_q) begin
				higher_any = higher_any | flags_q[k];
			end
		end
		q_last = !higher_any || (n_q == RES_W'(MAX_RESULTS - 1));
	end

	always_comb begin
		for (int k = 0; k < TIMERS; k++) begin
			if (IDX_W'(k) < pos_q) begin
				flags_compact[k] = flags_q[k];
			end else if (k + 1 < TIMERS) begin
				flags_compact[k] = flags_q[(k + 1) % TIMERS];
			end else begin
				flags_compact[k] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tpu_q       <= 16'd1;
			occ_q       <= '0;
			flags_q     <= '0;
			out_valid_q <= 1'b0;
			vld_s1      <= 1'b0;
			halt_q      <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				tpu_q <= cfg_wr_data;
			end
			vld_s1 <= issue_en;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						issue_q <= '0;
						halt_q  <= 1'b0;
						found_q <= 1'b0;
						stat_q  <= ST_OK;
						q_idx_q <= '0;
						n_q     <= '0;
						if (opcode != OP_QUERY) begin
							state_q <= S_WALK;
						end else if (occ_q == '0) begin
							stat_q  <= ST_NONE_SCHED;
							state_q <= S_FIN;
						end else if (flags_q == '0) begin
							stat_q  <= ST_NONE_EXP;
							state_q <= S_FIN;
						end else begin
							state_q <= S_QSCAN;
						end
					end
				end
				S_WALK: begin
					if (issue_en) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (proc_s1) begin
						case (op_q)
							OP_TICK: begin
								if (step.overdue) begin
									halt_q <= 1'b1;
									stat_q <= ST_OVERDUE;
								end else begin
									flags_q[idx_s1] <= step.expired;
								end
							end
							OP_START: begin
								if (step.match) begin
									found_q <= 1'b1;
									halt_q  <= 1'b1;
								end
							end
							default: begin
								if (!found_q && step.match) begin
									found_q <= 1'b1;
									pos_q   <= idx_s1;
								end
							end
						endcase
					end
					if (walk_done) begin
						state_q <= S_FIN;
						if (op_q == OP_START) begin
							if (found_q) begin
								stat_q <= ST_START_DUP;
							end else if (occ_q == CNT_W'(TIMERS)) begin
								stat_q <= ST_FULL;
							end else begin
								flags_q[occ_q[IDX_W-1:0]] <= (limit_q == 32'd0);
								occ_q <= occ_q + CNT_W'(1);
							end
						end else if (op_q == OP_STOP) begin
							if (!found_q) begin
								stat_q <= ST_STOP_UNK;
							end else begin
								flags_q <= flags_compact;
								occ_q   <= occ_q - CNT_W'(1);
							end
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						status          <= stat_q;
						expired_id      <= 8'd0;
						active_count    <= 5'(occ_q);
						timeout_pending <= |flags_q;
						last_of_run     <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				S_QSCAN: begin
					if (flags_q[q_idx_q]) begin
						state_q <= S_QRD;
					end else begin
						q_idx_q <= q_idx_q + IDX_W'(1);
					end
				end
				S_QRD: begin
					if (out_free) begin
						status          <= ST_OK;
						expired_id      <= rd_ent.id;
						active_count    <= 5'(occ_q);
						timeout_pending <= 1'b1;
						last_of_run     <= q_last;
						if (q_last) begin
							state_q <= S_IDLE;
						end else begin
							q_idx_q <= q_idx_q + IDX_W'(1);
							n_q     <= n_q + RES_W'(1);
							state_q <= S_QSCAN;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Command registers written only in the idle state, on entry to a walk or query; idx_s1 follows issue_q.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q    <= opcode;
			id_q    <= timer_id;
			limit_q <= limit;
		end
		idx_s1 <= issue_q[IDX_W-1:0];
	end

	assign out_valid = out_valid_q;

	`PTT_ASSERT_NOW(a_occ_bound, 1'b1, occ_q <= CNT_W'(TIMERS))
	`PTT_ASSERT_NOW(a_flags_in_table, (state_q == S_IDLE),
		(flags_q >> occ_q) == '0)
	`PTT_ASSERT_NEXT(a_busy_after_xfer, in_xfer, state_q != S_IDLE)
	`PTT_ASSERT_NEXT(a_query_continues, out_valid_q && !out_stall && !last_of_run
		&& (state_q == S_IDLE), 1'b0)

endmodule

`default_nettype wire

### dv/prescaled_timer_table_checker.sv
// Result checker for the prescaled timer table: watches both transfer channels,
// keeps its own copy of the timer table and prescale, and compares each result.
// Depends on ptt_pkg.

module prescaled_timer_table_checker
	import ptt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [7:0]  timer_id,
	input  wire logic [31:0] limit,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [2:0]  status,
	input  wire logic [7:0]  expired_id,
	input  wire logic [4:0]  active_count,
	input  wire logic        timeout_pending,
	input  wire logic        last_of_run,
	output int               mismatches,
	output int               awaited,
	output int               reports_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NO_SLOT = -1;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] id;
		logic [4:0] active;
		logic       pending;
		logic       last;
	} report_t;

	report_t     awaited_reports[$];
	logic [15:0] scale;
	logic [7:0]  tbl_id[PTT_TIMERS];
	logic [31:0] tbl_units[PTT_TIMERS];
	logic [15:0] tbl_ticks[PTT_TIMERS];
	int          held;

	function automatic logic is_expired(int slot);
		return tbl_units[slot] == 32'd0 && tbl_ticks[slot] == 16'd0;
	endfunction

	function automatic logic any_expired();
		for (int i = 0; i < held; i++)
			if (is_expired(i))
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic int slot_of(logic [7:0] id);
		for (int i = 0; i < held; i++)
			if (tbl_id[i] == id)
				return i;
		return NO_SLOT;
	endfunction

	// Active count and pending flag are taken after the command has been applied.
	function automatic void post_report(logic [2:0] st, logic [7:0] id, logic last);
		report_t r;
		r.status  = st;
		r.id      = id;
		r.active  = 5'(held);
		r.pending = any_expired();
		r.last    = last;
		awaited_reports.push_back(r);
	endfunction

	function automatic void apply_command(logic [1:0] op, logic [7:0] id, logic [31:0] lim);
		logic [2:0] st;
		int         pos;
		int         to_list;
		int         listed;
		st = ST_OK;
		case (op)
		OP_TICK: begin
			// The walk halts at the first expired timer; earlier slots keep their update.
			for (int i = 0; i < held; i++) begin
				if (tbl_ticks[i] != 16'd0) begin
					tbl_ticks[i] = tbl_ticks[i] - 16'd1;
				end else if (tbl_units[i] != 32'd0) begin
					tbl_units[i] = tbl_units[i] - 32'd1;
					tbl_ticks[i] = scale - 16'd1;
				end else begin
					st = ST_OVERDUE;
					break;
				end
			end
			post_report(st, 8'd0, 1'b1);
		end
		OP_START: begin
			if (slot_of(id) != NO_SLOT) begin
				st = ST_START_DUP;
			end else if (held >= PTT_TIMERS) begin
				st = ST_FULL;
			end else begin
				tbl_id[held]    = id;
				tbl_units[held] = lim;
				tbl_ticks[held] = 16'd0;
				held++;
			end
			post_report(st, 8'd0, 1'b1);
		end
		OP_STOP: begin
			pos = slot_of(id);
			if (pos == NO_SLOT) begin
				st = ST_STOP_UNK;
			end else begin
				for (int i = pos; i < held - 1; i++) begin
					tbl_id[i]    = tbl_id[i + 1];
					tbl_units[i] = tbl_units[i + 1];
					tbl_ticks[i] = tbl_ticks[i + 1];
				end
				held--;
			end
			post_report(st, 8'd0, 1'b1);
		end
		OP_QUERY: begin
			to_list = 0;
			for (int i = 0; i < held; i++)
				if (is_expired(i))
					to_list++;
			if (to_list > MAX_RESULTS)
				to_list = MAX_RESULTS;
			listed = 0;
			if (held == 0) begin
				post_report(ST_NONE_SCHED, 8'd0, 1'b1);
			end else if (to_list == 0) begin
				post_report(ST_NONE_EXP, 8'd0, 1'b1);
			end else begin
				for (int i = 0; i < held && listed < to_list; i++) begin
					if (is_expired(i)) begin
						listed++;
						post_report(ST_OK, tbl_id[i], listed == to_list);
					end
				end
			end
		end
		default: ;
		endcase
	endfunction

	// Results are compared before the command of the same edge is predicted.
	always @(posedge clk or negedge arst_n) begin
		report_t want;
		if (!arst_n) begin
			awaited_reports.delete();
			scale        = 16'd1;
			held         = 0;
			mismatches   = 0;
			reports_seen = 0;
		end else begin
			if (out_valid && !out_stall) begin
				reports_seen++;
				if (awaited_reports.size() == 0) begin
					$error("unexpected result: status %0d, expired_id %0d", status, expired_id);
					mismatches++;
				end else begin
					want = awaited_reports.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						mismatches++;
					end
					if (expired_id !== want.id) begin
						$error("expired_id: expected %0d, got %0d", want.id, expired_id);
						mismatches++;
					end
					if (active_count !== want.active) begin
						$error("active_count: expected %0d, got %0d", want.active, active_count);
						mismatches++;
					end
					if (timeout_pending !== want.pending) begin
						$error("timeout_pending: expected %0d, got %0d", want.pending,
							timeout_pending);
						mismatches++;
					end
					if (last_of_run !== want.last) begin
						$error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall)
				apply_command(opcode, timer_id, limit);
			if (cfg_wr_en)
				scale = cfg_wr_data;
		end
		awaited = awaited_reports.size();
	end

endmodule

### dv/prescaled_timer_table_tb.sv
// Top of the prescaled timer table testbench: clock, reset, command stimulus,
// receiver stalls and the verdict. Depends on ptt_pkg, prescaled_timer_table
// and prescaled_timer_table_checker.

module prescaled_timer_table_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ptt_pkg::*;

	localparam int PHASES           = 6;
	localparam int RANDOM_PER_PHASE = 40;
	localparam int DRAIN_CYCLES     = PTT_TIMERS + 8;
	localparam int HOLD_PHASE       = 4;
	localparam int HOLD_CYCLES      = 200;
	localparam int WATCHDOG_LIMIT   = 4000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  opcode = OP_TICK;
	logic [7:0]  timer_id = 8'd0;
	logic [31:0] limit = 32'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [7:0]  expired_id;
	logic [4:0]  active_count;
	logic        timeout_pending;
	logic        last_of_run;

	int          mismatches;
	int          awaited;
	int          reports_seen;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          hold_left = 0;
	int          commands_sent = 0;
	int          scales_used = 0;
	int          quiet_cycles = 0;
	logic [7:0]  id_flip = 8'd0;

	logic [15:0] phase_scale[PHASES] = '{16'd1, 16'd0, 16'd2, 16'hFFFF, 16'd3, 16'd1};
	int          phase_send_idle[PHASES] = '{0, 72, 0, 31, 0, 31};
	int          phase_stall[PHASES] = '{0, 0, 72, 31, 0, 31};

	always #2 clk = ~clk;

	prescaled_timer_table uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.opcode          (opcode),
		.timer_id        (timer_id),
		.limit           (limit),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.expired_id      (expired_id),
		.active_count    (active_count),
		.timeout_pending (timeout_pending),
		.last_of_run     (last_of_run)
	);

	prescaled_timer_table_checker watch (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.opcode          (opcode),
		.timer_id        (timer_id),
		.limit           (limit),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.expired_id      (expired_id),
		.active_count    (active_count),
		.timeout_pending (timeout_pending),
		.last_of_run     (last_of_run),
		.mismatches      (mismatches),
		.awaited         (awaited),
		.reports_seen    (reports_seen)
	);

	// Receiver side: a long hold-off when requested, random stalls otherwise.
	initial forever begin
		@(negedge clk);
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else begin
			out_stall = $urandom_range(99) < stall_pct;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("prescaled_timer_table_tb: done, errors");
				$finish;
			end
		end
	end

	// Valid stays high after a transfer; it only drops for an idle gap or a pause.
	task automatic send_command(logic [1:0] op, logic [7:0] id, logic [31:0] lim);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid = 1'b1;
		opcode   = op;
		timer_id = id;
		limit    = lim;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		commands_sent++;
	endtask

	task automatic set_scale(logic [15:0] value);
		in_valid = 1'b0;
		while (awaited != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		scales_used++;
	endtask

	task automatic run_directed();
		send_command(OP_QUERY, 8'd0, 32'd0);
		send_command(OP_TICK, 8'd0, 32'd0);
		send_command(OP_STOP, 8'h07, 32'd0);
		send_command(OP_START, 8'hFF, 32'hFFFF_FFFF);
		send_command(OP_START, 8'h00, 32'd0);
		send_command(OP_START, 8'h00, 32'd5);
		send_command(OP_QUERY, 8'd0, 32'd0);
		// The expired timer in the second slot halts this walk.
		send_command(OP_TICK, 8'd0, 32'd0);
		send_command(OP_STOP, 8'h00, 32'd0);
		send_command(OP_QUERY, 8'd0, 32'd0);
		for (int k = 8'h10; k < 8'h1E; k++)
			send_command(OP_START, 8'(k), 32'd1);
		send_command(OP_START, 8'h80, 32'd0);
		send_command(OP_START, 8'h40, 32'd3);
		// Duplicate id on a full table must report the duplicate.
		send_command(OP_START, 8'h10, 32'd3);
		send_command(OP_TICK, 8'd0, 32'd0);
		send_command(OP_QUERY, 8'd0, 32'd0);
	endtask

	task automatic send_random_command();
		int          roll;
		logic [1:0]  op;
		logic [7:0]  id;
		logic [31:0] lim;
		roll = $urandom_range(99);
		op = roll < 35 ? OP_TICK : roll < 65 ? OP_START : roll < 85 ? OP_STOP : OP_QUERY;
		// A small id pool keeps stops and duplicates hitting; the rest is noise.
		if ($urandom_range(99) < 85)
			id = 8'($urandom_range(0, 23)) ^ id_flip;
		else
			id = 8'($urandom);
		roll = $urandom_range(99);
		if (roll < 50)
			lim = 32'($urandom_range(0, 4));
		else if (roll < 80)
			lim = 32'($urandom_range(0, 40));
		else if (roll < 90)
			lim = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
		else
			lim = 32'($urandom);
		send_command(op, id, lim);
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		for (int p = 0; p < PHASES; p++) begin
			set_scale(phase_scale[p]);
			send_idle_pct = phase_send_idle[p];
			stall_pct     = phase_stall[p];
			id_flip       = 8'($urandom);
			if (p == 0)
				run_directed();
			if (p == HOLD_PHASE)
				hold_left = HOLD_CYCLES;
			repeat (RANDOM_PER_PHASE) send_random_command();
		end
		in_valid = 1'b0;
		while (awaited != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("prescaled_timer_table_tb: %0d commands sent, %0d results checked",
			commands_sent, reports_seen);
		$display("prescaled_timer_table_tb: %0d prescale settings, idle and stall mixes",
			scales_used);
		if (mismatches == 0)
			$display("prescaled_timer_table_tb: done, clean");
		else
			$display("prescaled_timer_table_tb: done, errors");
		$finish;
	end

endmodule
